// ===== hw/rtl/edp_pkg.sv =====
// Shared types, constants and datapath command codes for the edge diffraction point finder.
package edp_pkg;

    localparam int ITER_LIMIT = 32;
    localparam int ITER_W     = $clog2(ITER_LIMIT + 1);
    localparam int DIV_STEPS  = 24;

    localparam logic [24:0] ONE_Q24     = 25'h1000000;
    localparam logic [23:0] INV_PHI_Q24 = 24'd10368890;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_CONE  = 2'd2;

    localparam logic [1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [1:0] CFG_ITOL     = 2'd1;
    localparam logic [1:0] CFG_CTOL     = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_DEG,
        OP_MUL_OFF,
        OP_SET_C,
        OP_SET_D,
        OP_MUL_PT,
        OP_SET_PT,
        OP_CLR_ACC,
        OP_DIFF,
        OP_MUL_SQ,
        OP_ACC,
        OP_SQRT_GO,
        OP_SAVE_LEN,
        OP_STORE_FC,
        OP_STORE_FD,
        OP_STEP,
        OP_MID,
        OP_VE,
        OP_MUL_EE,
        OP_SAVE_LE,
        OP_ZERO,
        OP_CLR_DOT,
        OP_MUL_DOT,
        OP_DACC,
        OP_MUL_DEN,
        OP_DIV_GO,
        OP_SAVE_COS,
        OP_FINAL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;
        logic       sel;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic go_c;
        logic tol_hit;
        logic sqrt_busy;
        logic div_busy;
        logic zero_len;
    } t_stat;

endpackage

// ===== hw/rtl/edge_diffraction_point_finder_unit.sv =====
// Top level of the edge diffraction point finder: configuration registers and unit wiring.
//
//  channel   | direction | beat taken when              | payload
//  ----------+-----------+------------------------------+------------------------------------
//  command   | in        | start high, busy low         | i_tx_*, i_rx_*, i_edge_*
//  result    | out       | o_done high (one cycle)      | o_edge_param, o_point_*, o_status
//  config    | in        | i_cfg_we high                | i_cfg_idx, i_cfg_data
//
// A degenerate edge gives its result beat without a search. Otherwise the two starting
// probes and every search step each evaluate both path lengths, mostly the two square
// roots; a cosine that saturates skips the division steps, and a zero-length segment
// ends the item before the cosine test.
// One command is in flight at a time; busy stays high until the result cycle.
// Synchronous active-low reset returns the sequencer to idle and the configuration registers to defaults.
module edge_diffraction_point_finder_unit import edp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_tx_x,
    input  logic signed [31:0] i_tx_y,
    input  logic signed [31:0] i_tx_z,
    input  logic signed [31:0] i_rx_x,
    input  logic signed [31:0] i_rx_y,
    input  logic signed [31:0] i_rx_z,
    input  logic signed [31:0] i_edge_start_x,
    input  logic signed [31:0] i_edge_start_y,
    input  logic signed [31:0] i_edge_start_z,
    input  logic signed [31:0] i_edge_vec_x,
    input  logic signed [31:0] i_edge_vec_y,
    input  logic signed [31:0] i_edge_vec_z,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_idx,
    input  logic        [24:0] i_cfg_data,
    output logic               o_done,
    output logic        [24:0] o_edge_param,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic        [1:0]  o_status
);

    logic        [5:0]  r_max_iter;
    logic        [24:0] r_itol;
    logic        [24:0] r_ctol;
    logic signed [31:0] w_tx [3];
    logic signed [31:0] w_rx [3];
    logic signed [31:0] w_s  [3];
    logic signed [31:0] w_v  [3];
    logic signed [31:0] w_point [3];
    t_cmd               w_cmd;
    t_stat              w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= 6'd32;
            r_itol     <= 25'd17;
            r_ctol     <= 25'd1678;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[5:0];
                CFG_ITOL:     r_itol     <= i_cfg_data;
                CFG_CTOL:     r_ctol     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_tx = '{i_tx_x, i_tx_y, i_tx_z};
    assign w_rx = '{i_rx_x, i_rx_y, i_rx_z};
    assign w_s  = '{i_edge_start_x, i_edge_start_y, i_edge_start_z};
    assign w_v  = '{i_edge_vec_x, i_edge_vec_y, i_edge_vec_z};

    edp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_max_iter (r_max_iter),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    edp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_tx         (w_tx),
        .i_rx         (w_rx),
        .i_s          (w_s),
        .i_v          (w_v),
        .i_itol       (r_itol),
        .i_ctol       (r_ctol),
        .o_stat       (w_stat),
        .o_edge_param (o_edge_param),
        .o_point      (w_point),
        .o_status     (o_status)
    );

    assign o_point_x = w_point[0];
    assign o_point_y = w_point[1];
    assign o_point_z = w_point[2];

endmodule

// ===== hw/rtl/edp_sqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module edp_sqrt import edp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_x,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_x    <= i_x;
            r_res  <= '0;
            r_bit  <= 64'd1 << 62;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_busy <= (r_bit[63:2] != '0);
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[31:0];

endmodule

// ===== hw/rtl/edp_div.sv =====
// Restoring divider for a Q1.24 ratio saturated at one.
module edp_div import edp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [62:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [24:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rem;
    logic [63:0]      r_den;
    logic [24:0]      r_quot;
    logic [64:0]      w_rem2;

    assign w_rem2 = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_den <= i_den;
            if ({1'b0, i_num} >= i_den) begin
                r_quot <= ONE_Q24;
                r_busy <= 1'b0;
            end else begin
                r_rem  <= {1'b0, i_num};
                r_quot <= '0;
                r_cnt  <= CNT_W'(DIV_STEPS);
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            if (w_rem2 >= {1'b0, r_den}) begin
                r_rem  <= 64'(w_rem2 - {1'b0, r_den});
                r_quot <= {r_quot[23:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[63:0];
                r_quot <= {r_quot[23:0], 1'b0};
            end
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/edp_dp.sv =====
// Datapath: operand registers, shared multiplier, square root and divider units.
module edp_dp import edp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_tx [3],
    input  logic signed [31:0] i_rx [3],
    input  logic signed [31:0] i_s  [3],
    input  logic signed [31:0] i_v  [3],
    input  logic        [24:0] i_itol,
    input  logic        [24:0] i_ctol,
    output t_stat              o_stat,
    output logic        [24:0] o_edge_param,
    output logic signed [31:0] o_point [3],
    output logic        [1:0]  o_status
);

    localparam logic signed [31:0] BIG_LIM = 32'sd536870912;
    localparam logic signed [33:0] S_MAX   = 34'sd2147483647;
    localparam logic signed [33:0] S_MIN   = -34'sd2147483648;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        mag32 = x[31] ? 32'(~x) + 32'd1 : 32'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        if (x > S_MAX) begin
            sat32 = S_MAX[31:0];
        end else if (x < S_MIN) begin
            sat32 = S_MIN[31:0];
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    logic signed [31:0] r_tx [3];
    logic signed [31:0] r_rx [3];
    logic signed [31:0] r_s  [3];
    logic signed [31:0] r_v  [3];
    logic signed [31:0] r_ve [3];
    logic signed [31:0] r_dt [3];
    logic signed [31:0] r_dr [3];
    logic signed [33:0] r_p  [3];
    logic        [24:0] r_a, r_b, r_c, r_d, r_t;
    logic        [32:0] r_fc, r_fd;
    logic        [63:0] r_prod;
    logic               r_pneg;
    logic        [63:0] r_acc;
    logic signed [63:0] r_dot;
    logic        [31:0] r_lt, r_lr, r_le;
    logic        [24:0] r_ctx, r_crx;
    logic               r_go_c;
    logic        [1:0]  r_status;

    logic        [1:0]  w_k;
    logic        [24:0] w_width;
    logic        [24:0] w_off;
    logic        [31:0] w_ma, w_mb;
    logic               w_mneg;
    logic        [63:0] w_prod;
    logic signed [31:0] w_vk, w_wk, w_vek;
    logic        [31:0] w_vmag, w_wmag, w_vemag;
    logic        [32:0] w_q33;
    logic signed [33:0] w_qs, w_pt;
    logic signed [31:0] w_qsel;
    logic signed [34:0] w_e;
    logic        [34:0] w_emag;
    logic        [32:0] w_er;
    logic signed [31:0] w_diff;
    logic               w_big;
    logic        [29:0] w_vr;
    logic signed [31:0] w_verd;
    logic signed [63:0] w_sprod;
    logic        [62:0] w_dmag;
    logic        [25:0] w_mid;
    logic        [24:0] w_cdiff;
    logic               w_sqrt_busy, w_div_busy;
    logic        [31:0] w_root;
    logic        [24:0] w_quot;

    assign w_k     = i_cmd.k;
    assign w_width = (r_b > r_a) ? r_b - r_a : '0;
    assign w_off   = 25'((r_prod + 64'd8388608) >> 24);

    assign w_vk    = r_v[w_k];
    assign w_wk    = i_cmd.sel ? r_dr[w_k] : r_dt[w_k];
    assign w_vek   = r_ve[w_k];
    assign w_vmag  = mag32(w_vk);
    assign w_wmag  = mag32(w_wk);
    assign w_vemag = mag32(w_vek);

    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_mneg = 1'b0;
        unique case (i_cmd.op)
            OP_MUL_OFF: begin
                w_ma = 32'(w_width);
                w_mb = 32'(INV_PHI_Q24);
            end
            OP_MUL_PT: begin
                w_ma   = w_vmag;
                w_mb   = 32'(r_t);
                w_mneg = w_vk[31];
            end
            OP_MUL_SQ: begin
                w_ma = w_wmag;
                w_mb = w_wmag;
            end
            OP_MUL_EE: begin
                w_ma = w_vemag;
                w_mb = w_vemag;
            end
            OP_MUL_DOT: begin
                w_ma   = w_wmag;
                w_mb   = w_vemag;
                w_mneg = w_wk[31] ^ w_vek[31];
            end
            OP_MUL_DEN: begin
                w_ma = i_cmd.sel ? r_lr : r_lt;
                w_mb = r_le;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);

    // Point on the edge: start plus the rounded scaled edge vector.
    assign w_q33 = 33'((r_prod + 64'd8388608) >> 24);
    assign w_qs  = r_pneg ? -$signed({1'b0, w_q33}) : $signed({1'b0, w_q33});
    assign w_pt  = 34'(r_s[w_k]) + w_qs;

    // Segment component from the anchor to the point, rounded to Q16.14.
    assign w_qsel = i_cmd.sel ? r_rx[w_k] : r_tx[w_k];
    assign w_e    = 35'(r_p[w_k]) - 35'(w_qsel);
    assign w_emag = w_e[34] ? 35'(-w_e) : 35'(w_e);
    assign w_er   = 33'((w_emag + 35'd2) >> 2);
    assign w_diff = w_e[34] ? -$signed(w_er[31:0]) : $signed(w_er[31:0]);

    always_comb begin
        w_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_big = w_big | (r_v[i] >= BIG_LIM) | (r_v[i] <= -BIG_LIM);
        end
    end

    assign w_vr   = 30'((33'(w_vmag) + 33'd2) >> 2);
    assign w_verd = w_vk[31] ? -$signed({2'b00, w_vr}) : $signed({2'b00, w_vr});

    assign w_sprod = r_pneg ? -$signed(r_prod) : $signed(r_prod);
    assign w_dmag  = r_dot[63] ? 63'(-r_dot) : r_dot[62:0];
    assign w_mid   = 26'(({1'b0, r_a} + {1'b0, r_b} + 26'd1) >> 1);
    assign w_cdiff = (r_ctx > r_crx) ? r_ctx - r_crx : r_crx - r_ctx;

    edp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.op == OP_SQRT_GO),
        .i_x     (r_acc),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    edp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.op == OP_DIV_GO),
        .i_num   (w_dmag),
        .i_den   (r_prod),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_pneg <= w_mneg;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_tx <= i_tx;
                r_rx <= i_rx;
                r_s  <= i_s;
                r_v  <= i_v;
                r_a  <= '0;
                r_b  <= ONE_Q24;
            end
            OP_DEG: begin
                r_t      <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_p[i] <= 34'(r_s[i]);
                end
                r_status <= ST_DEGEN;
            end
            OP_SET_C: begin
                r_c <= r_b - w_off;
                r_t <= r_b - w_off;
            end
            OP_SET_D: begin
                r_d <= r_a + w_off;
                r_t <= r_a + w_off;
            end
            OP_SET_PT:  r_p[w_k] <= w_pt;
            OP_CLR_ACC: r_acc <= '0;
            OP_DIFF: begin
                if (i_cmd.sel) begin
                    r_dr[w_k] <= w_diff;
                end else begin
                    r_dt[w_k] <= w_diff;
                end
            end
            OP_ACC: r_acc <= r_acc + r_prod;
            OP_SAVE_LEN: begin
                if (i_cmd.sel) begin
                    r_lr <= w_root;
                end else begin
                    r_lt <= w_root;
                end
            end
            OP_STORE_FC: r_fc <= {1'b0, r_lt} + {1'b0, r_lr};
            OP_STORE_FD: r_fd <= {1'b0, r_lt} + {1'b0, r_lr};
            OP_STEP: begin
                if (r_fc < r_fd) begin
                    r_b    <= r_d;
                    r_d    <= r_c;
                    r_fd   <= r_fc;
                    r_go_c <= 1'b1;
                end else begin
                    r_a    <= r_c;
                    r_c    <= r_d;
                    r_fc   <= r_fd;
                    r_go_c <= 1'b0;
                end
            end
            OP_MID:      r_t <= (w_mid > 26'(ONE_Q24)) ? ONE_Q24 : w_mid[24:0];
            OP_VE:       r_ve[w_k] <= w_big ? w_verd : w_vk;
            OP_SAVE_LE:  r_le <= w_root;
            OP_ZERO:     r_status <= ST_CONE;
            OP_CLR_DOT:  r_dot <= '0;
            OP_DACC:     r_dot <= r_dot + w_sprod;
            OP_SAVE_COS: begin
                if (i_cmd.sel) begin
                    r_crx <= w_quot;
                end else begin
                    r_ctx <= w_quot;
                end
            end
            OP_FINAL: r_status <= (w_cdiff <= i_ctol) ? ST_OK : ST_CONE;
            default: begin
            end
        endcase
    end

    assign o_stat.degen     = (r_v[0] == '0) && (r_v[1] == '0) && (r_v[2] == '0);
    assign o_stat.go_c      = r_go_c;
    assign o_stat.tol_hit   = (w_width < i_itol);
    assign o_stat.sqrt_busy = w_sqrt_busy;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.zero_len  = (r_lt == '0) || (r_lr == '0) || (r_le == '0);

    assign o_edge_param = r_t;
    assign o_status     = r_status;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_point[i] = sat32(r_p[i]);
        end
    end

endmodule

// ===== hw/rtl/edp_ctrl.sv =====
// Controller: sequences the search, the path evaluations and the cone test.
module edp_ctrl import edp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [5:0] i_max_iter,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_DEG, S_OFF, S_PROBE, S_PT_MUL, S_PT_SET,
        S_CLR, S_DIFF, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT, S_SAVE_LEN,
        S_PATH_END, S_STEP, S_MID, S_VE, S_E_CLR, S_E_MUL, S_E_ACC, S_E_GO,
        S_E_WAIT, S_E_SAVE, S_ZCHK, S_ZERO, S_D_CLR, S_D_MUL, S_D_ACC, S_DEN,
        S_DIV_GO, S_DIV_WAIT, S_DIV_SAVE, S_FINAL
    } t_state;

    typedef enum logic [1:0] {PH_INIT_C, PH_INIT_D, PH_ITER, PH_FINAL} t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [1:0]        r_k, n_k;
    logic              r_sel, n_sel;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] w_limit;
    logic [ITER_W-1:0] w_iter_inc;

    always_comb begin
        if (int'(i_max_iter) < ITER_LIMIT) begin
            w_limit = ITER_W'(i_max_iter);
        end else begin
            w_limit = ITER_W'(ITER_LIMIT);
        end
    end

    assign w_iter_inc = r_iter + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_k       = r_k;
        n_sel     = r_sel;
        n_iter    = r_iter;
        n_done    = 1'b0;
        o_cmd.op  = OP_NOP;
        o_cmd.k   = r_k;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_phase = PH_INIT_C;
                n_state = i_stat.degen ? S_DEG : S_OFF;
            end
            S_DEG: begin
                o_cmd.op = OP_DEG;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_OFF: begin
                o_cmd.op = OP_MUL_OFF;
                n_state  = S_PROBE;
            end
            S_PROBE: begin
                if (r_phase == PH_INIT_C || (r_phase == PH_ITER && i_stat.go_c)) begin
                    o_cmd.op = OP_SET_C;
                end else begin
                    o_cmd.op = OP_SET_D;
                end
                n_k     = '0;
                n_state = S_PT_MUL;
            end
            S_PT_MUL: begin
                o_cmd.op = OP_MUL_PT;
                n_state  = S_PT_SET;
            end
            S_PT_SET: begin
                o_cmd.op = OP_SET_PT;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_sel   = 1'b0;
                    n_state = S_CLR;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_PT_MUL;
                end
            end
            S_CLR: begin
                o_cmd.op = OP_CLR_ACC;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_SQRT_GO;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_SQRT_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = S_SAVE_LEN;
                end
            end
            S_SAVE_LEN: begin
                o_cmd.op = OP_SAVE_LEN;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_state = S_PATH_END;
                end
            end
            S_PATH_END: begin
                unique case (r_phase)
                    PH_INIT_C: begin
                        o_cmd.op = OP_STORE_FC;
                        n_phase  = PH_INIT_D;
                        n_state  = S_OFF;
                    end
                    PH_INIT_D: begin
                        o_cmd.op = OP_STORE_FD;
                        n_phase  = PH_ITER;
                        n_iter   = '0;
                        n_state  = (w_limit == '0) ? S_MID : S_STEP;
                    end
                    PH_ITER: begin
                        o_cmd.op = i_stat.go_c ? OP_STORE_FC : OP_STORE_FD;
                        n_iter   = w_iter_inc;
                        if (i_stat.tol_hit || w_iter_inc == w_limit) begin
                            n_state = S_MID;
                        end else begin
                            n_state = S_STEP;
                        end
                    end
                    PH_FINAL: begin
                        n_k     = '0;
                        n_state = S_VE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_OFF;
            end
            S_MID: begin
                o_cmd.op = OP_MID;
                n_phase  = PH_FINAL;
                n_k      = '0;
                n_state  = S_PT_MUL;
            end
            S_VE: begin
                o_cmd.op = OP_VE;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_E_CLR;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_E_CLR: begin
                o_cmd.op = OP_CLR_ACC;
                n_state  = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.op = OP_MUL_EE;
                n_state  = S_E_ACC;
            end
            S_E_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_E_GO;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_E_MUL;
                end
            end
            S_E_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = S_E_SAVE;
                end
            end
            S_E_SAVE: begin
                o_cmd.op = OP_SAVE_LE;
                n_state  = S_ZCHK;
            end
            S_ZCHK: begin
                n_sel   = 1'b0;
                n_k     = '0;
                n_state = i_stat.zero_len ? S_ZERO : S_D_CLR;
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_D_CLR: begin
                o_cmd.op = OP_CLR_DOT;
                n_k      = '0;
                n_state  = S_D_MUL;
            end
            S_D_MUL: begin
                o_cmd.op = OP_MUL_DOT;
                n_state  = S_D_ACC;
            end
            S_D_ACC: begin
                o_cmd.op = OP_DACC;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_DEN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_D_MUL;
                end
            end
            S_DEN: begin
                o_cmd.op = OP_MUL_DEN;
                n_state  = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DIV_SAVE;
                end
            end
            S_DIV_SAVE: begin
                o_cmd.op = OP_SAVE_COS;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_D_CLR;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.op = OP_FINAL;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_INIT_C;
            r_k     <= '0;
            r_sel   <= 1'b0;
            r_iter  <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
            r_sel   <= n_sel;
            r_iter  <= n_iter;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/edp_chk.sv =====
// Port-level checker for the edge diffraction point finder, bound to the top level.
module edp_chk import edp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [24:0] o_edge_param,
    input logic [1:0]  o_status
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command beat did not raise busy");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result beat");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat lasted more than one cycle");

    a_degen_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_DEGEN |-> o_edge_param == '0)
        else $error("degenerate edge reported a nonzero edge parameter");

endmodule

bind edge_diffraction_point_finder_unit edp_chk u_edp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_edge_param (o_edge_param),
    .o_status     (o_status)
);
